// ----- rtl/core/scl_pkg.sv -----
package scl_pkg;

  localparam int CONTROL_SLOTS_DEF     = 16;
  localparam int LINE_BUFFER_BYTES_DEF = 128;
  localparam int LEN_W                 = 8;
  localparam int QUEUE_DEPTH           = 2;

  // characters
  localparam logic [7:0] CH_NUL     = 8'd0;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_COMMA   = 8'h2c;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UC_A    = 8'h41;
  localparam logic [7:0] CH_UC_D    = 8'h44;
  localparam logic [7:0] CH_UC_E    = 8'h45;
  localparam logic [7:0] CH_UC_I    = 8'h49;
  localparam logic [7:0] CH_UC_N    = 8'h4e;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_VT      = 8'd11;
  localparam logic [7:0] CH_FF      = 8'd12;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'd32;

  // control kinds
  localparam logic [1:0] KIND_DIGITAL = 2'd0;
  localparam logic [1:0] KIND_ENCODER = 2'd1;
  localparam logic [1:0] KIND_ANALOG  = 2'd2;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  // line status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // token positions
  localparam logic [1:0] TOK_KEY    = 2'd0;
  localparam logic [1:0] TOK_INDEX  = 2'd1;
  localparam logic [1:0] TOK_VALUE  = 2'd2;
  localparam logic [1:0] TOK_IGNORE = 2'd3;

  // number phases
  localparam logic [1:0] PH_WAIT   = 2'd0;
  localparam logic [1:0] PH_SIGN   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_STOP   = 2'd3;

  // key match progress
  localparam logic [3:0] KEY_IDLE     = 4'd0;
  localparam logic [3:0] KEY_DOLLAR   = 4'd1;
  localparam logic [3:0] KEY_D        = 4'd2;
  localparam logic [3:0] KEY_E        = 4'd3;
  localparam logic [3:0] KEY_A        = 4'd4;
  localparam logic [3:0] KEY_DI       = 4'd5;
  localparam logic [3:0] KEY_EN       = 4'd6;
  localparam logic [3:0] KEY_AN       = 4'd7;
  localparam logic [3:0] KEY_MISMATCH = 4'd15;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] index;
    logic signed [31:0] value;
    logic [1:0]         status;
    logic               enc_store;
  } line_rec_t;

endpackage

// ----- rtl/core/scl_front.sv -----
module scl_front #(
  parameter int CONTROL_SLOTS     = scl_pkg::CONTROL_SLOTS_DEF,
  parameter int LINE_BUFFER_BYTES = scl_pkg::LINE_BUFFER_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              beat,
  input  logic [7:0]        rx_byte,
  output logic              push,
  output scl_pkg::line_rec_t push_rec
);
  import scl_pkg::*;

  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_BUFFER_BYTES - 1);

  function automatic logic [3:0] key_next(input logic [3:0] p, input logic [7:0] c);
    logic [3:0] r;
    r = KEY_MISMATCH;
    unique case (p)
      KEY_IDLE:   if (c == CH_DOLLAR) r = KEY_DOLLAR;
      KEY_DOLLAR: begin
        if (c == CH_UC_D) r = KEY_D;
        else if (c == CH_UC_E) r = KEY_E;
        else if (c == CH_UC_A) r = KEY_A;
      end
      KEY_D:      if (c == CH_UC_I) r = KEY_DI;
      KEY_E:      if (c == CH_UC_N) r = KEY_EN;
      KEY_A:      if (c == CH_UC_N) r = KEY_AN;
      default:    r = KEY_MISMATCH;
    endcase
    return r;
  endfunction

  // acc * 10 +/- digit, clamped to 32-bit signed
  function automatic logic signed [31:0] acc_step(input logic signed [31:0] acc,
                                                  input logic neg, input logic [3:0] d);
    logic signed [35:0] a;
    logic signed [35:0] dd;
    logic signed [35:0] v;
    logic signed [31:0] r;
    a  = $signed({{4{acc[31]}}, acc});
    dd = $signed({32'd0, d});
    v  = (a <<< 3) + (a <<< 1);
    v  = neg ? v - dd : v + dd;
    if (v > 36'sd2147483647) r = 32'sh7fffffff;
    else if (v < -36'sd2147483648) r = 32'sh80000000;
    else r = $signed(v[31:0]);
    return r;
  endfunction

  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               ovf_r, ovf_nxt;
  logic [1:0]         tok_r, tok_nxt;
  logic               open_r, open_nxt;
  logic [3:0]         key_r, key_nxt;
  logic [1:0]         phase_r, phase_nxt;
  logic               neg_r, neg_nxt;
  logic signed [31:0] idx_acc_r, idx_acc_nxt;
  logic signed [31:0] val_acc_r, val_acc_nxt;

  logic               is_blank, is_digit, idx_oor;
  logic signed [31:0] cur_acc, step_acc;
  logic [1:0]         kind;

  assign is_blank = (rx_byte == CH_SPACE) || (rx_byte == CH_TAB) || (rx_byte == CH_VT) ||
                    (rx_byte == CH_FF) || (rx_byte == CH_CR);
  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign cur_acc  = (tok_r == TOK_INDEX) ? idx_acc_r : val_acc_r;
  assign step_acc = acc_step(cur_acc, neg_r, rx_byte[3:0]);

  always_comb begin
    len_nxt     = len_r;
    ovf_nxt     = ovf_r;
    tok_nxt     = tok_r;
    open_nxt    = open_r;
    key_nxt     = key_r;
    phase_nxt   = phase_r;
    neg_nxt     = neg_r;
    idx_acc_nxt = idx_acc_r;
    val_acc_nxt = val_acc_r;
    if (beat) begin
      if (rx_byte == CH_NEWLINE) begin
        len_nxt     = '0;
        ovf_nxt     = 1'b0;
        tok_nxt     = TOK_KEY;
        open_nxt    = 1'b0;
        key_nxt     = KEY_IDLE;
        phase_nxt   = PH_WAIT;
        neg_nxt     = 1'b0;
        idx_acc_nxt = '0;
        val_acc_nxt = '0;
      end else begin
        if (len_r >= LEN_LIMIT) ovf_nxt = 1'b1;
        else len_nxt = len_r + LEN_W'(1);
        if (tok_r != TOK_IGNORE) begin
          priority if (rx_byte == CH_NUL) begin
            tok_nxt = TOK_IGNORE;
          end else if (rx_byte == CH_COMMA) begin
            if (open_r) begin
              tok_nxt   = tok_r + 2'd1;
              open_nxt  = 1'b0;
              phase_nxt = PH_WAIT;
              neg_nxt   = 1'b0;
            end
          end else begin
            open_nxt = 1'b1;
            if (tok_r == TOK_KEY) begin
              key_nxt = key_next(key_r, rx_byte);
            end else if (phase_r != PH_STOP) begin
              priority if (phase_r == PH_WAIT && is_blank) begin
                phase_nxt = PH_WAIT;
              end else if (phase_r == PH_WAIT &&
                           (rx_byte == CH_PLUS || rx_byte == CH_MINUS)) begin
                neg_nxt   = (rx_byte == CH_MINUS);
                phase_nxt = PH_SIGN;
              end else if (!is_digit) begin
                phase_nxt = PH_STOP;
              end else begin
                phase_nxt = PH_DIGITS;
                if (tok_r == TOK_INDEX) idx_acc_nxt = step_acc;
                else val_acc_nxt = step_acc;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= '0;
      ovf_r     <= 1'b0;
      tok_r     <= TOK_KEY;
      open_r    <= 1'b0;
      key_r     <= KEY_IDLE;
      phase_r   <= PH_WAIT;
      neg_r     <= 1'b0;
      idx_acc_r <= '0;
      val_acc_r <= '0;
    end else begin
      len_r     <= len_nxt;
      ovf_r     <= ovf_nxt;
      tok_r     <= tok_nxt;
      open_r    <= open_nxt;
      key_r     <= key_nxt;
      phase_r   <= phase_nxt;
      neg_r     <= neg_nxt;
      idx_acc_r <= idx_acc_nxt;
      val_acc_r <= val_acc_nxt;
    end
  end

  // classify the finished line
  assign idx_oor = idx_acc_r[31] || ($unsigned(idx_acc_r) >= 32'(CONTROL_SLOTS));

  always_comb begin
    unique case (key_r)
      KEY_DI:  kind = KIND_DIGITAL;
      KEY_EN:  kind = KIND_ENCODER;
      KEY_AN:  kind = KIND_ANALOG;
      default: kind = KIND_UNKNOWN;
    endcase
  end

  always_comb begin
    push = beat && (rx_byte == CH_NEWLINE);
    if (ovf_r) begin
      push_rec.kind      = KIND_UNKNOWN;
      push_rec.index     = '0;
      push_rec.value     = '0;
      push_rec.status    = ST_OVERFLOW;
      push_rec.enc_store = 1'b0;
    end else begin
      push_rec.kind      = kind;
      push_rec.index     = idx_acc_r;
      push_rec.value     = val_acc_r;
      push_rec.status    = (kind != KIND_UNKNOWN && idx_oor) ? ST_RANGE : ST_OK;
      push_rec.enc_store = (kind == KIND_ENCODER) && !idx_oor;
    end
  end

endmodule

// ----- rtl/core/scl_queue.sv -----
module scl_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  scl_pkg::line_rec_t push_rec,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output scl_pkg::line_rec_t head_rec
);
  import scl_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  line_rec_t        entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head_rec   = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + CNT_W'(1);
    else if (pop && !push) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL) else $error("queue count beyond depth");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop) else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid) else $error("queue pop while empty");
`endif

endmodule

// ----- rtl/core/scl_back.sv -----
module scl_back #(
  parameter int CONTROL_SLOTS = scl_pkg::CONTROL_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  scl_pkg::line_rec_t head_rec,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output scl_pkg::line_rec_t out_rec,
  output logic [31:0]        out_total
);
  import scl_pkg::*;

  localparam int SLOT_W = (CONTROL_SLOTS > 1) ? $clog2(CONTROL_SLOTS) : 1;

  logic [31:0]        total_mem [CONTROL_SLOTS];
  logic [CONTROL_SLOTS-1:0] total_vld_r;

  logic               s1_valid_r;
  line_rec_t          s1_rec_r;
  logic [31:0]        mem_q_r;
  logic               vld_q_r;
  logic               fwd_r;
  logic [31:0]        fwd_data_r;

  logic               out_valid_r;
  line_rec_t          out_rec_r;
  logic [31:0]        out_total_r;

  logic [SLOT_W-1:0]  rd_slot, wr_slot;
  logic               s1_go, s1_load, wr_en;
  logic [31:0]        old_total, sum;

  assign rd_slot   = head_rec.index[SLOT_W-1:0];
  assign wr_slot   = s1_rec_r.index[SLOT_W-1:0];
  assign s1_go     = s1_valid_r && (!out_valid_r || out_ready);
  assign s1_load   = head_valid && (!s1_valid_r || s1_go);
  assign pop       = s1_load;
  assign wr_en     = s1_go && s1_rec_r.enc_store;
  assign old_total = fwd_r ? fwd_data_r : (vld_q_r ? mem_q_r : 32'd0);
  assign sum       = old_total + $unsigned(s1_rec_r.value);

  // encoder totals: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) total_mem[wr_slot] <= sum;
    if (s1_load) mem_q_r <= total_mem[rd_slot];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_vld_r <= '0;
    end else if (wr_en) begin
      total_vld_r[wr_slot] <= 1'b1;
    end
  end

  // read side bookkeeping, with bypass when the line ahead hits the same slot
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_rec_r   <= head_rec;
      vld_q_r    <= total_vld_r[rd_slot];
      fwd_r      <= wr_en && (wr_slot == rd_slot);
      fwd_data_r <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_rec_r   <= s1_rec_r;
      out_total_r <= s1_rec_r.enc_store ? sum : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_load || (s1_valid_r && !s1_go);
      out_valid_r <= s1_go || (out_valid_r && !out_ready);
    end
  end

  assign out_valid = out_valid_r;
  assign out_rec   = out_rec_r;
  assign out_total = out_total_r;

`ifndef NO_ASSERTIONS
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_go |=> s1_valid_r && $stable(s1_rec_r))
    else $error("stage one lost a stalled line");
  a_total_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_rec_r.kind != KIND_ENCODER || out_rec_r.status != ST_OK)
    |-> out_total_r == 32'd0) else $error("encoder total on a line that stores none");
  a_overflow_rec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rec_r.status == ST_OVERFLOW
    |-> out_rec_r.kind == KIND_UNKNOWN && out_rec_r.index == 0 && out_rec_r.value == 0)
    else $error("overflow report carries line data");
`endif

endmodule

// ----- rtl/core/serial_control_line_parser.sv -----
// channel | ports                                   | direction | moves
// input   | in_valid in_ready in_rx_byte            | in        | one received byte per beat
// result  | out_valid out_ready out_control_kind     | out       | one report per line
//         | out_control_index out_parsed_value       |           |
//         | out_encoder_total out_line_status        |           |
// one byte per cycle while in_ready is high; a line crosses queue, s1 and out regs
// the encoder total read-modify-write is a two-stage memory pipeline with a bypass,
// so while out_ready holds, reports can leave every cycle, even for the same slot
// a two-entry line queue sits between the parser and the store; in_ready drops only
// when that queue is full because the result side stalls
// synchronous active-low reset clears the line state, the queue and all encoder totals
module serial_control_line_parser #(
  parameter int CONTROL_SLOTS     = scl_pkg::CONTROL_SLOTS_DEF,
  parameter int LINE_BUFFER_BYTES = scl_pkg::LINE_BUFFER_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_control_kind,
  output logic signed [31:0] out_control_index,
  output logic signed [31:0] out_parsed_value,
  output logic signed [31:0] out_encoder_total,
  output logic [1:0]         out_line_status
);
  import scl_pkg::*;

  logic      beat, push, q_full, pop, head_valid;
  line_rec_t push_rec, head_rec, out_rec;
  logic [31:0] out_total;

  assign in_ready = !q_full;
  assign beat     = in_valid && in_ready;

  scl_front #(
    .CONTROL_SLOTS     (CONTROL_SLOTS),
    .LINE_BUFFER_BYTES (LINE_BUFFER_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .beat     (beat),
    .rx_byte  (in_rx_byte),
    .push     (push),
    .push_rec (push_rec)
  );

  scl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_rec   (push_rec),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_rec   (head_rec)
  );

  scl_back #(
    .CONTROL_SLOTS (CONTROL_SLOTS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_rec    (out_rec),
    .out_total  (out_total)
  );

  assign out_control_kind  = out_rec.kind;
  assign out_control_index = out_rec.index;
  assign out_parsed_value  = out_rec.value;
  assign out_encoder_total = $signed(out_total);
  assign out_line_status   = out_rec.status;

endmodule
